[rtl/csvq_pkg.sv]
// ============================================================================
// csvq_pkg - shared types and constants of the CSV quote parser
// Quote DFA transition function, byte classes, register map, beat layout.
// ============================================================================
`default_nettype none

package csvq_pkg;

  localparam int unsigned NUM_LANES = 4;

  typedef logic [2:0] dfa_state_t;

  // DFA states; a lane in DEAD_STATE stays there and gives no marks.
  localparam dfa_state_t DFA_S0     = 3'd0;
  localparam dfa_state_t DFA_S1     = 3'd1;
  localparam dfa_state_t DFA_S2     = 3'd2;
  localparam dfa_state_t DFA_S3     = 3'd3;
  localparam dfa_state_t DEAD_STATE = 3'd4;

  // Byte classes (DFA input symbols)
  typedef enum logic [1:0] {
    SYM_DELIM = 2'd0,
    SYM_QUOTE = 2'd1,
    SYM_OTHER = 2'd2
  } sym_e;

  // Register index (paddr word offset)
  typedef enum logic [1:0] {
    REG_FIELD_DELIM  = 2'd0,
    REG_RECORD_DELIM = 2'd1,
    REG_QUOTE_CHAR   = 2'd2
  } reg_idx_e;

  localparam logic [7:0] FIELD_DELIM_RST  = 8'd44;
  localparam logic [7:0] RECORD_DELIM_RST = 8'd10;
  localparam logic [7:0] QUOTE_CHAR_RST   = 8'd34;

  typedef struct packed {
    logic [7:0] field_delim;
    logic [7:0] record_delim;
    logic [7:0] quote_char;
  } cfg_t;

  typedef struct packed {
    sym_e sym;
    logic is_field;
    logic is_record;
  } byte_class_t;

  typedef struct packed {
    dfa_state_t state;     // state after the byte, DEAD_STATE if dead
    logic       quoted;    // quote flag after the byte
    logic       unquoted;  // lane alive and outside quotes: may mark
  } lane_res_t;

  // Result beat, lowest field in the lowest bits
  typedef struct packed {
    logic             pad;
    logic             chain_error;
    logic [15:0]      block_number;
    dfa_state_t       end_state_lane3;
    dfa_state_t       end_state_lane2;
    dfa_state_t       end_state_lane1;
    dfa_state_t       end_state_lane0;
    logic             record_mark_chosen;
    logic             field_mark_chosen;
    logic [3:0]       record_marks;
    logic [3:0]       field_marks;
  } out_beat_t;

  function automatic dfa_state_t dfa_next(dfa_state_t s, sym_e sym);
    dfa_state_t n;
    n = DEAD_STATE;
    unique case (s)
      DFA_S0: begin
        unique case (sym)
          SYM_DELIM: n = DFA_S0;
          SYM_QUOTE: n = DFA_S3;
          default:   n = DFA_S1;
        endcase
      end
      DFA_S1: begin
        unique case (sym)
          SYM_DELIM: n = DFA_S0;
          default:   n = DFA_S1;
        endcase
      end
      DFA_S2: begin
        unique case (sym)
          SYM_DELIM: n = DFA_S0;
          SYM_QUOTE: n = DFA_S3;
          default:   n = DEAD_STATE;
        endcase
      end
      DFA_S3: begin
        unique case (sym)
          SYM_QUOTE: n = DFA_S2;
          default:   n = DFA_S3;
        endcase
      end
      default: n = DEAD_STATE;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/csvq_apb_regs.sv]
// ============================================================================
// csvq_apb_regs - configuration registers
// Delimiter and quote byte registers behind a simple APB slave.
// ============================================================================
`default_nettype none

module csvq_apb_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output csvq_pkg::cfg_t         cfg_o
);
  import csvq_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.field_delim  <= FIELD_DELIM_RST;
      cfg_q.record_delim <= RECORD_DELIM_RST;
      cfg_q.quote_char   <= QUOTE_CHAR_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_FIELD_DELIM:  cfg_q.field_delim  <= pwdata[7:0];
        REG_RECORD_DELIM: cfg_q.record_delim <= pwdata[7:0];
        REG_QUOTE_CHAR:   cfg_q.quote_char   <= pwdata[7:0];
        default: ;  // unmapped word, write dropped
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (idx)
      REG_FIELD_DELIM:  prdata = {24'd0, cfg_q.field_delim};
      REG_RECORD_DELIM: prdata = {24'd0, cfg_q.record_delim};
      REG_QUOTE_CHAR:   prdata = {24'd0, cfg_q.quote_char};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/csvq_classify.sv]
// ============================================================================
// csvq_classify - byte classifier
// Maps a byte to its DFA symbol; field delimiter wins over record, then quote.
// ============================================================================
`default_nettype none

module csvq_classify (
  input  wire logic [7:0]            byte_i,
  input  wire csvq_pkg::cfg_t        cfg_i,
  output csvq_pkg::byte_class_t      cls_o
);
  import csvq_pkg::*;

  logic hit_field, hit_record, hit_quote;

  assign hit_field  = (byte_i == cfg_i.field_delim);
  assign hit_record = (byte_i == cfg_i.record_delim);
  assign hit_quote  = (byte_i == cfg_i.quote_char);

  always_comb begin
    cls_o.is_field  = hit_field;
    cls_o.is_record = !hit_field && hit_record;
    priority if (hit_field || hit_record) begin
      cls_o.sym = SYM_DELIM;
    end else if (hit_quote) begin
      cls_o.sym = SYM_QUOTE;
    end else begin
      cls_o.sym = SYM_OTHER;
    end
  end

endmodule

`default_nettype wire

[rtl/csvq_lane_step.sv]
// ============================================================================
// csvq_lane_step - one DFA lane, one byte
// Next state, quote flag and mark permission of a single speculative lane.
// ============================================================================
`default_nettype none

module csvq_lane_step (
  input  wire csvq_pkg::dfa_state_t  state_i,
  input  wire logic                  quoted_i,
  input  wire csvq_pkg::sym_e        sym_i,
  output csvq_pkg::lane_res_t        res_o
);
  import csvq_pkg::*;

  logic       live;
  dfa_state_t nxt;

  assign live = (state_i < DEAD_STATE);
  assign nxt  = dfa_next(state_i, sym_i);

  always_comb begin
    res_o.state    = DEAD_STATE;
    res_o.quoted   = quoted_i;
    res_o.unquoted = 1'b0;
    if (live) begin
      res_o.state = nxt;
      // entering S3 opens a quote, entering S2 closes it
      if (nxt == DFA_S3) begin
        res_o.quoted = 1'b1;
      end else if (nxt == DFA_S2) begin
        res_o.quoted = 1'b0;
      end
      res_o.unquoted = !res_o.quoted;
    end
  end

endmodule

`default_nettype wire

[rtl/speculative_csv_quote_parser_core.sv]
// ============================================================================
// speculative_csv_quote_parser_core - speculative four-lane CSV quote parser
// Runs the quote DFA from all four start states per block, marks delimiters
// per lane and along the chained start state, reports lane end states.
// ============================================================================
//
//  channel  | dir | signals                          | payload
//  ---------+-----+----------------------------------+---------------------------
//  s_axis   | in  | tvalid/tready/tdata[7:0]/tlast   | data_byte, last_in_block
//  m_axis   | out | tvalid/tready/tdata[39:0]/tlast  | marks, end states, block_end
//  apb      | in  | psel/penable/pwrite/paddr[3:0]   | delimiter/quote registers
//
//  One byte per cycle sustained while m_axis takes its results; a byte's
//  result passes the input register, then the result register, to m_axis.
//  The lane step is a table lookup and two compares; chaining only needs the
//  lane end states of the byte in flight, so no stall is ever self-inflicted.
//  Reset: lanes restart in states 0..3, chain starts in 0, block count 0,
//  registers at comma / newline / double quote.
//  A stalled m_axis holds its result; s_axis keeps taking one byte while the
//  held result waits, then backs off.
// ============================================================================
`default_nettype none

module speculative_csv_quote_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // last_in_block
  // result stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [3:0] field_marks, [7:4] record_marks,
                                           // [8] field_mark_chosen,
                                           // [9] record_mark_chosen,
                                           // [12:10] end_state_lane0,
                                           // [15:13] end_state_lane1,
                                           // [18:16] end_state_lane2,
                                           // [21:19] end_state_lane3,
                                           // [37:22] block_number,
                                           // [38] chain_error, [39] zero
  output logic             m_axis_tlast,   // block_end
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import csvq_pkg::*;

  cfg_t cfg;

  csvq_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic       advance;

  // the byte in the input register moves on when the result slot is empty or its result is being taken
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Classify and step all four lanes
  // --------------------------------------------------------------------------
  byte_class_t cls;

  csvq_classify u_classify (
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .cls_o  (cls)
  );

  dfa_state_t lane_state_q [NUM_LANES];
  logic       quoted_q     [NUM_LANES];
  lane_res_t  lane_res     [NUM_LANES];
  logic [1:0] chosen_start_q;
  logic [15:0] block_counter_q;

  logic [NUM_LANES-1:0] fmarks, rmarks;

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    csvq_lane_step u_step (
      .state_i  (lane_state_q[k]),
      .quoted_i (quoted_q[k]),
      .sym_i    (cls.sym),
      .res_o    (lane_res[k])
    );
    assign fmarks[k] = cls.is_field  && lane_res[k].unquoted;
    assign rmarks[k] = cls.is_record && lane_res[k].unquoted;
  end

  // chaining: end state of the chosen lane picks the next block's start, state 0 if it is dead
  dfa_state_t chosen_end;
  logic       chain_dead;

  assign chosen_end = lane_res[chosen_start_q].state;
  assign chain_dead = (chosen_end >= DEAD_STATE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        lane_state_q[k] <= dfa_state_t'(k);
        quoted_q[k]     <= 1'b0;
      end
      chosen_start_q  <= 2'd0;
      block_counter_q <= 16'd0;
    end else if (advance) begin
      if (in_last_q) begin
        // block done: restart speculation in every start state
        for (int k = 0; k < NUM_LANES; k++) begin
          lane_state_q[k] <= dfa_state_t'(k);
          quoted_q[k]     <= 1'b0;
        end
        chosen_start_q  <= chain_dead ? 2'd0 : chosen_end[1:0];
        block_counter_q <= block_counter_q + 16'd1;
      end else begin
        for (int k = 0; k < NUM_LANES; k++) begin
          lane_state_q[k] <= lane_res[k].state;
          quoted_q[k]     <= lane_res[k].quoted;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  out_beat_t beat_d, out_q;
  logic      out_last_q;

  always_comb begin
    beat_d                    = '0;
    beat_d.field_marks        = fmarks;
    beat_d.record_marks       = rmarks;
    beat_d.field_mark_chosen  = fmarks[chosen_start_q];
    beat_d.record_mark_chosen = rmarks[chosen_start_q];
    beat_d.block_number       = block_counter_q;
    if (in_last_q) begin
      beat_d.end_state_lane0 = lane_res[0].state;
      beat_d.end_state_lane1 = lane_res[1].state;
      beat_d.end_state_lane2 = lane_res[2].state;
      beat_d.end_state_lane3 = lane_res[3].state;
      beat_d.chain_error     = chain_dead;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q      <= beat_d;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_err_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.chain_error |-> out_last_q)
    else $error("chain_error outside block end");

  a_dead_chain_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q && chain_dead |=> chosen_start_q == 2'd0)
    else $error("dead chain did not restart in state 0");

  a_block_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> block_counter_q == 16'($past(block_counter_q) + 16'd1))
    else $error("block counter not advanced at block end");

  a_end_states_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |->
      out_q.end_state_lane0 == 3'd0 && out_q.end_state_lane1 == 3'd0 &&
      out_q.end_state_lane2 == 3'd0 && out_q.end_state_lane3 == 3'd0)
    else $error("end states set outside block end");

  a_lane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_state_q[0] <= DEAD_STATE && lane_state_q[1] <= DEAD_STATE &&
    lane_state_q[2] <= DEAD_STATE && lane_state_q[3] <= DEAD_STATE)
    else $error("lane state out of range");

endmodule

`default_nettype wire
